// File: src/stepper_step_dir_controller_assert.svh
// assertion macros shared by the stepper controller modules
// they expect signals named clk and rst in the module that uses them
`ifndef STEPPER_STEP_DIR_CONTROLLER_ASSERT_SVH
`define STEPPER_STEP_DIR_CONTROLLER_ASSERT_SVH

`ifndef ASSERT_OFF
`define SSDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SSDC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) pre |=> post) else $error(msg);
`else
`define SSDC_ASSERT(lbl, prop, msg)
`define SSDC_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// File: src/ssdc_pkg.sv
`default_nettype none

package ssdc_pkg;

  localparam int PERIOD_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int HP_W     = 16;
  localparam int POS_W    = 32;
  localparam int CMD_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CMD_W-1:0] CMD_TICK = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RUN  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REL  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ABS  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STOP = 3'd4;
  localparam logic [CMD_W-1:0] CMD_HOME = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_POS_FLOOR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_CEILING = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOME_HP     = 2'd2;

  localparam logic [HP_W-1:0] HOME_HP_RESET = 16'd1000;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_TICK,
    OP_RUN,
    OP_STOP,
    OP_MOVE_REL,
    OP_MOVE_ABS,
    OP_HOME
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [POS_W-1:0]  amount;
    logic [HP_W-1:0]   hp;
    logic              fwd;
    logic              limit;
  } entry_t;

endpackage

`default_nettype wire

// File: src/ssdc_front.sv
`default_nettype none

module ssdc_front (
  input  wire logic [ssdc_pkg::CMD_W-1:0] cmd,
  input  wire logic [ssdc_pkg::POS_W-1:0] amount,
  input  wire logic [ssdc_pkg::HP_W-1:0]  half_period,
  input  wire logic                       run_forward,
  input  wire logic                       limit_hit,
  input  wire logic [ssdc_pkg::HP_W-1:0]  home_half_period,
  output ssdc_pkg::entry_t                entry
);

  logic hp_zero;

  assign hp_zero = (half_period == '0);

  always_comb begin
    entry.amount = amount;
    entry.hp     = half_period;
    entry.fwd    = run_forward;
    entry.limit  = limit_hit;
    unique case (cmd)
      ssdc_pkg::CMD_TICK: entry.op = ssdc_pkg::OP_TICK;
      ssdc_pkg::CMD_RUN:  entry.op = hp_zero ? ssdc_pkg::OP_STOP : ssdc_pkg::OP_RUN;
      ssdc_pkg::CMD_REL: begin
        entry.op = (hp_zero || amount == '0) ? ssdc_pkg::OP_NOP : ssdc_pkg::OP_MOVE_REL;
      end
      ssdc_pkg::CMD_ABS:  entry.op = hp_zero ? ssdc_pkg::OP_NOP : ssdc_pkg::OP_MOVE_ABS;
      ssdc_pkg::CMD_STOP: entry.op = ssdc_pkg::OP_STOP;
      ssdc_pkg::CMD_HOME: begin
        entry.op = ssdc_pkg::OP_HOME;
        // zero speed on home picks the configured homing speed
        if (hp_zero) begin
          entry.hp = home_half_period;
        end
      end
      default:            entry.op = ssdc_pkg::OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

// File: src/ssdc_queue.sv
`default_nettype none

module ssdc_queue #(
  parameter int DEPTH = ssdc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire ssdc_pkg::entry_t  push_entry,
  input  wire logic              pop,
  output ssdc_pkg::entry_t       head,
  output logic                   not_empty,
  output logic                   full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  ssdc_pkg::entry_t slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign not_empty = (count != '0);
  assign full      = (count == FULL_COUNT);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

`include "stepper_step_dir_controller_assert.svh"

  `SSDC_ASSERT(a_count_bound, (count <= FULL_COUNT), "queue count beyond depth")
  `SSDC_ASSERT_NEXT(a_pop_nonempty, (pop), ($past(count) != '0), "pop from empty queue")

endmodule

`default_nettype wire

// File: src/ssdc_back.sv
`default_nettype none

module ssdc_back #(
  parameter int PERIOD_BITS = ssdc_pkg::PERIOD_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             q_valid,
  input  wire ssdc_pkg::entry_t                 entry,
  output logic                                  q_pop,
  input  wire logic signed [ssdc_pkg::POS_W-1:0] pos_floor,
  input  wire logic signed [ssdc_pkg::POS_W-1:0] pos_ceiling,
  output logic                                  result_valid,
  input  wire logic                             result_stall,
  output logic                                  step_level,
  output logic                                  dir_level,
  output logic                                  enable_level,
  output logic signed [ssdc_pkg::POS_W-1:0]     position_now,
  output logic                                  move_done,
  output logic                                  is_homed,
  output logic                                  is_homing
);

  localparam int P = PERIOD_BITS;
  localparam int W = ssdc_pkg::POS_W;
  localparam logic [32:0] PMAX = (33'd1 << P) - 33'd1;

  logic [P-1:0]        tick_count, tick_count_next;
  logic [P-1:0]        step_half_period, step_half_period_next;
  logic signed [W-1:0] position, position_next;
  logic [W-1:0]        pulses_left, pulses_left_next;
  logic                running, running_next;
  logic                direction, direction_next;
  logic                edge_phase, edge_phase_next;
  logic                homing_active, homing_active_next;
  logic                homed_flag, homed_flag_next;

  logic [P-1:0]        tc_inc;
  logic [P-1:0]        hp_fit;
  logic signed [W-1:0] pos_step;
  logic [W-1:0]        delta;
  logic                at_limit;

  assign q_pop = q_valid && (!result_valid || !result_stall);

  always_comb begin
    if (33'(entry.hp) > PMAX) begin
      hp_fit = '1;
    end else begin
      hp_fit = P'(entry.hp);
    end
  end

  assign tc_inc   = tick_count + P'(1);
  assign pos_step = direction ? position + W'(1) : position - W'(1);
  assign delta    = (entry.op == ssdc_pkg::OP_MOVE_ABS) ? entry.amount - position
                                                        : entry.amount;
  assign at_limit = homed_flag && ((direction && pos_step >= pos_ceiling) ||
                                   (!direction && pos_step <= pos_floor));

  always_comb begin
    tick_count_next       = tick_count;
    step_half_period_next = step_half_period;
    position_next         = position;
    pulses_left_next      = pulses_left;
    running_next          = running;
    direction_next        = direction;
    edge_phase_next       = edge_phase;
    homing_active_next    = homing_active;
    homed_flag_next       = homed_flag;
    if (q_pop) begin
      unique case (entry.op)
        ssdc_pkg::OP_TICK: begin
          if (running) begin
            if (tc_inc != '0 && tc_inc < step_half_period) begin
              tick_count_next = tc_inc;
            end else begin
              tick_count_next = '0;
              edge_phase_next = !edge_phase;
              // rising step edge completes a pulse
              if (!edge_phase) begin
                if (homing_active && entry.limit) begin
                  running_next          = 1'b0;
                  pulses_left_next      = '0;
                  step_half_period_next = '0;
                  position_next         = '0;
                  homed_flag_next       = 1'b1;
                  homing_active_next    = 1'b0;
                end else begin
                  position_next = pos_step;
                  if (at_limit || pulses_left == W'(1)) begin
                    running_next          = 1'b0;
                    pulses_left_next      = '0;
                    step_half_period_next = '0;
                  end else if (pulses_left != '0) begin
                    pulses_left_next = pulses_left - W'(1);
                  end
                end
              end
            end
          end
        end
        ssdc_pkg::OP_RUN: begin
          direction_next = entry.fwd;
          if (!running) begin
            pulses_left_next = '0;
          end
          step_half_period_next = hp_fit;
          tick_count_next       = '0;
          running_next          = 1'b1;
        end
        ssdc_pkg::OP_STOP: begin
          running_next          = 1'b0;
          pulses_left_next      = '0;
          step_half_period_next = '0;
        end
        ssdc_pkg::OP_MOVE_REL, ssdc_pkg::OP_MOVE_ABS: begin
          if (delta != '0) begin
            direction_next        = !delta[W-1];
            pulses_left_next      = delta[W-1] ? W'(0) - delta : delta;
            step_half_period_next = hp_fit;
            tick_count_next       = '0;
            running_next          = 1'b1;
          end
        end
        ssdc_pkg::OP_HOME: begin
          homing_active_next    = 1'b1;
          homed_flag_next       = 1'b0;
          direction_next        = 1'b1;
          pulses_left_next      = '0;
          step_half_period_next = hp_fit;
          tick_count_next       = '0;
          running_next          = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count       <= '0;
      step_half_period <= '0;
      position         <= '0;
      pulses_left      <= '0;
      running          <= 1'b0;
      direction        <= 1'b1;
      edge_phase       <= 1'b0;
      homing_active    <= 1'b0;
      homed_flag       <= 1'b0;
      result_valid     <= 1'b0;
    end else begin
      tick_count       <= tick_count_next;
      step_half_period <= step_half_period_next;
      position         <= position_next;
      pulses_left      <= pulses_left_next;
      running          <= running_next;
      direction        <= direction_next;
      edge_phase       <= edge_phase_next;
      homing_active    <= homing_active_next;
      homed_flag       <= homed_flag_next;
      if (q_pop) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // result payload snapshots the state left by the item
  always_ff @(posedge clk) begin
    if (q_pop) begin
      step_level   <= edge_phase_next;
      dir_level    <= direction_next;
      enable_level <= running_next;
      position_now <= position_next;
      move_done    <= (pulses_left_next == '0);
      is_homed     <= homed_flag_next;
      is_homing    <= homing_active_next;
    end
  end

`include "stepper_step_dir_controller_assert.svh"

  `SSDC_ASSERT(a_idle_clear, (!running |-> (pulses_left == '0 && step_half_period == '0)), "idle")
  `SSDC_ASSERT(a_home_excl, (!(homing_active && homed_flag)), "homing and homed together")
  `SSDC_ASSERT_NEXT(a_no_pop_hold, (!q_pop), (position == $past(position) && running == $past(running)), "moved")

endmodule

`default_nettype wire

// File: src/stepper_step_dir_controller.sv
// step/dir pulse generator for one stepper driver
// item channel: item_valid/item_stall carry a command or a timer tick
// (cmd, amount, half_period, run_forward, limit_hit), taken when valid and
// not stall. result channel: result_valid/result_stall carry one status item
// (step, dir, enable, position, move_done, homed, homing) per input item,
// in order.
// result path: the taken item is written into the queue, then executed into
// the result register once it is at the queue head and result_stall does not hold it
// throughput: one item per cycle while result_stall is low, set by the execute stage
// that owns the motion state; a small queue sits between decode and execute
// receiver stall: the result register holds, the queue fills, and
// item_stall rises once the queue is full; nothing is dropped
// config: cfg_we/cfg_index/cfg_data write the low and high soft position
// limits and the homing half-period; write only while no items
// are in flight
// reset (rst, synchronous): motion stopped, position zero, direction
// forward, not homed, queue empty, config back to defaults
`default_nettype none

module stepper_step_dir_controller #(
  parameter int PERIOD_BITS = ssdc_pkg::PERIOD_BITS_DEF,
  parameter int QUEUE_DEPTH = ssdc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   item_valid,
  output logic                                        item_stall,
  input  wire logic [ssdc_pkg::CMD_W-1:0]             cmd,
  input  wire logic signed [ssdc_pkg::POS_W-1:0]      amount,
  input  wire logic [ssdc_pkg::HP_W-1:0]              half_period,
  input  wire logic                                   run_forward,
  input  wire logic                                   limit_hit,
  output logic                                        result_valid,
  input  wire logic                                   result_stall,
  output logic                                        step_level,
  output logic                                        dir_level,
  output logic                                        enable_level,
  output logic signed [ssdc_pkg::POS_W-1:0]           position_now,
  output logic                                        move_done,
  output logic                                        is_homed,
  output logic                                        is_homing,
  input  wire logic                                   cfg_we,
  input  wire logic [ssdc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [ssdc_pkg::CFG_DATA_W-1:0]        cfg_data
);

  logic signed [ssdc_pkg::POS_W-1:0] pos_floor;
  logic signed [ssdc_pkg::POS_W-1:0] pos_ceiling;
  logic [ssdc_pkg::HP_W-1:0]         home_half_period;

  ssdc_pkg::entry_t front_entry;
  ssdc_pkg::entry_t head_entry;
  logic             q_full;
  logic             q_not_empty;
  logic             q_pop;
  logic             push;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_floor        <= '0;
      pos_ceiling      <= '0;
      home_half_period <= ssdc_pkg::HOME_HP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ssdc_pkg::REG_POS_FLOOR:   pos_floor        <= cfg_data;
        ssdc_pkg::REG_POS_CEILING: pos_ceiling      <= cfg_data;
        ssdc_pkg::REG_HOME_HP:     home_half_period <= cfg_data[ssdc_pkg::HP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign item_stall = q_full;
  assign push       = item_valid && !q_full;

  ssdc_front u_front (
    .cmd              (cmd),
    .amount           (amount),
    .half_period      (half_period),
    .run_forward      (run_forward),
    .limit_hit        (limit_hit),
    .home_half_period (home_half_period),
    .entry            (front_entry)
  );

  ssdc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (front_entry),
    .pop        (q_pop),
    .head       (head_entry),
    .not_empty  (q_not_empty),
    .full       (q_full)
  );

  ssdc_back #(
    .PERIOD_BITS (PERIOD_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_not_empty),
    .entry        (head_entry),
    .q_pop        (q_pop),
    .pos_floor    (pos_floor),
    .pos_ceiling  (pos_ceiling),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .step_level   (step_level),
    .dir_level    (dir_level),
    .enable_level (enable_level),
    .position_now (position_now),
    .move_done    (move_done),
    .is_homed     (is_homed),
    .is_homing    (is_homing)
  );

endmodule

`default_nettype wire
